// ===== design/iprt_pkg.sv =====
// ----------------------------------------------------------------------------
// iprt_pkg: shared types and constants for the IPv6 route table
// Request and result payloads, status codes, flag bits and prefix masks.
// ----------------------------------------------------------------------------
`default_nettype none

package iprt_pkg;

  localparam int TableEntries = 32;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;

  localparam logic [2:0] REQ_ADD      = 3'd0;
  localparam logic [2:0] REQ_DEL      = 3'd1;
  localparam logic [2:0] REQ_DEL_DEV  = 3'd2;
  localparam logic [2:0] REQ_ADD_CONN = 3'd3;
  localparam logic [2:0] REQ_DEL_CONN = 3'd4;
  localparam logic [2:0] REQ_EXPIRE   = 3'd5;
  localparam logic [2:0] REQ_LOOKUP   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOENT    = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_UNREACH  = 3'd5;
  localparam logic [2:0] ST_NOTAVAIL = 3'd6;

  localparam logic [2:0] FL_GATEWAY   = 3'd1;
  localparam logic [2:0] FL_CONNECTED = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  pfx_len;
    logic [63:0] gateway_hi;
    logic [63:0] gateway_lo;
    logic [31:0] metric;
    logic [2:0]  route_flags;
    logic [63:0] expire_time;
    logic [15:0] device_id;
    logic [15:0] iface_index;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_prefix_hi;
    logic [63:0] out_prefix_lo;
    logic [7:0]  out_prefix_len;
    logic [63:0] out_gateway_hi;
    logic [63:0] out_gateway_lo;
    logic [31:0] out_metric;
    logic [2:0]  out_flags;
    logic [15:0] out_iface;
    logic [15:0] out_device_id;
    logic [5:0]  removed_count;
    logic [5:0]  live_count;
  } rsp_t;

  // one table row
  typedef struct packed {
    logic [63:0] pfx_hi;
    logic [63:0] pfx_lo;
    logic [7:0]  len;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [31:0] cost;
    logic [2:0]  kind;
    logic [63:0] expiry;
    logic [15:0] iface;
    logic [15:0] device;
    logic [15:0] refs;
  } row_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;    // latch request, start scan
    logic          scan;    // examine row at scan index
    logic          finish;  // apply the write and build the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;  // scan index at last row
  } sts_t;

  function automatic logic [63:0] mask_hi(input logic [7:0] len);
    logic [63:0] m;
    if (len == 8'd0) m = '0;
    else if (len >= 8'd64) m = '1;
    else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> len[5:0]);
    return m;
  endfunction

  function automatic logic [63:0] mask_lo(input logic [7:0] len);
    logic [63:0] m;
    if (len <= 8'd64) m = '0;
    else if (len >= 8'd128) m = '1;
    else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> len[5:0]);
    return m;
  endfunction

  function automatic logic is_ll(input logic [63:0] hi);
    return hi[63:54] == 10'h3FA;
  endfunction

endpackage

`default_nettype wire

// ===== design/iprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// iprt_ctrl: request sequencer
// Accept a request, walk the table one row per cycle, finish, present result.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output iprt_pkg::cmd_t     cmd_o,
  input  iprt_pkg::sts_t     sts_i
);
  import iprt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

`default_nettype wire

// ===== design/iprt_dp.sv =====
// ----------------------------------------------------------------------------
// iprt_dp: route table storage and scan datapath
// Row memory, live bits, per-row match/select logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iprt_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  iprt_pkg::req_t     req_i,
  input  iprt_pkg::cmd_t     cmd_i,
  output iprt_pkg::sts_t     sts_o,
  output iprt_pkg::rsp_t     rsp_o
);
  import iprt_pkg::*;

  row_t                    mem [TableEntries];
  logic [TableEntries-1:0] live_q;
  req_t                    req_q;
  logic [IdxW-1:0]         idx_q;
  logic                    done_q;      // first-match search finished
  logic                    hit_q;
  logic [IdxW-1:0]         hit_idx_q;
  logic                    free_q;
  logic [IdxW-1:0]         free_idx_q;
  logic [CntW-1:0]         removed_q;
  logic                    found_q, amb_q, scope_q;
  logic [7:0]              best_len_q;
  logic [31:0]             best_met_q;
  logic [15:0]             best_if_q;
  row_t                    best_q;
  row_t                    hit_row_q;
  rsp_t                    rsp_q;
  rsp_t                    rsp_d;
  row_t                    rd_row_q;
  logic [IdxW-1:0]         rd_idx;

  // request-derived terms
  logic [63:0] phi, plo;
  logic        plen_ok, bad, exp_del;
  row_t        cur;
  logic        cur_live, key_eq, conn_eq, cur_exp, usable, better, tie;

  assign plen_ok = req_q.pfx_len <= 8'd128;
  assign phi = req_q.addr_hi & mask_hi(req_q.pfx_len);
  assign plo = req_q.addr_lo & mask_lo(req_q.pfx_len);
  assign exp_del = (req_q.expire_time != '1) && (req_q.expire_time <= req_q.now_time);

  always_comb begin
    bad = 1'b0;
    unique case (req_q.req_type)
      REQ_ADD: bad = !plen_ok || req_q.device_id == '0 ||
                     (req_q.route_flags & FL_CONNECTED) != '0 ||
                     req_q.gateway_hi[63:56] == 8'hFF ||
                     (((req_q.route_flags & FL_GATEWAY) == '0) !=
                      (req_q.gateway_hi == '0 && req_q.gateway_lo == '0));
      REQ_DEL: bad = !plen_ok || (req_q.route_flags & FL_CONNECTED) != '0;
      REQ_ADD_CONN: bad = !plen_ok || req_q.device_id == '0;
      REQ_DEL_CONN: bad = !plen_ok;
      REQ_DEL_DEV, REQ_EXPIRE, REQ_LOOKUP: bad = 1'b0;
      default: bad = 1'b1;
    endcase
  end

  // fetch one row ahead: row 0 on load, the next row on every scan step
  assign rd_idx = cmd_i.load ? '0 : idx_q + IdxW'(1);
  assign cur = rd_row_q;
  assign cur_live = live_q[idx_q];
  assign key_eq = cur.pfx_hi == phi && cur.pfx_lo == plo && cur.len == req_q.pfx_len &&
                  cur.gw_hi == req_q.gateway_hi && cur.gw_lo == req_q.gateway_lo &&
                  cur.device == req_q.device_id && cur.kind == req_q.route_flags;
  assign conn_eq = cur.pfx_hi == phi && cur.pfx_lo == plo && cur.len == req_q.pfx_len &&
                   cur.device == req_q.device_id && cur.kind == FL_CONNECTED;
  assign cur_exp = cur.expiry != '1 && req_q.now_time >= cur.expiry;
  assign usable = cur_live && !cur_exp &&
                  (req_q.iface_index == '0 || cur.iface == req_q.iface_index) &&
                  (req_q.addr_hi & mask_hi(cur.len)) == cur.pfx_hi &&
                  (req_q.addr_lo & mask_lo(cur.len)) == cur.pfx_lo;
  assign better = !found_q || cur.len > best_len_q ||
                  (cur.len == best_len_q && cur.cost < best_met_q);
  assign tie = cur.len == best_len_q && cur.cost == best_met_q;

  assign sts_o.last = idx_q == IdxW'(TableEntries - 1);

  // final write decision
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  row_t            wr_row;
  logic            set_live, clr_live;
  logic [2:0]      st;
  logic [TableEntries-1:0] live_next;
  logic [CntW-1:0] live_cnt;

  always_comb begin
    wr_en = 1'b0; wr_idx = hit_idx_q; wr_row = hit_row_q;
    set_live = 1'b0; clr_live = 1'b0; st = ST_OK;
    if (bad) st = ST_INVALID;
    else begin
      unique case (req_q.req_type)
        REQ_ADD, REQ_DEL: begin
          if (req_q.req_type == REQ_DEL || exp_del) begin
            if (hit_q) clr_live = 1'b1;
            else if (req_q.req_type == REQ_DEL) st = ST_NOENT;
          end else if (!hit_q && !free_q) st = ST_NOSPACE;
          else begin
            wr_en = 1'b1; set_live = 1'b1;
            wr_idx = hit_q ? hit_idx_q : free_idx_q;
            wr_row.pfx_hi = phi; wr_row.pfx_lo = plo; wr_row.len = req_q.pfx_len;
            wr_row.gw_hi = req_q.gateway_hi; wr_row.gw_lo = req_q.gateway_lo;
            wr_row.cost = req_q.metric; wr_row.kind = req_q.route_flags;
            wr_row.expiry = req_q.expire_time; wr_row.iface = req_q.iface_index;
            wr_row.device = req_q.device_id;
            wr_row.refs = hit_q ? hit_row_q.refs : 16'd0;
          end
        end
        REQ_ADD_CONN: begin
          if (hit_q) begin
            if (hit_row_q.refs == '1) st = ST_OVERFLOW;
            else begin
              wr_en = 1'b1; wr_row.refs = hit_row_q.refs + 16'd1;
            end
          end else if (!free_q) st = ST_NOSPACE;
          else begin
            wr_en = 1'b1; set_live = 1'b1; wr_idx = free_idx_q;
            wr_row.pfx_hi = phi; wr_row.pfx_lo = plo; wr_row.len = req_q.pfx_len;
            wr_row.gw_hi = '0; wr_row.gw_lo = '0; wr_row.cost = '0;
            wr_row.kind = FL_CONNECTED; wr_row.expiry = '1;
            wr_row.iface = req_q.iface_index; wr_row.device = req_q.device_id;
            wr_row.refs = 16'd1;
          end
        end
        REQ_DEL_CONN: begin
          if (!hit_q) st = ST_NOENT;
          else if (hit_row_q.refs > 16'd1) begin
            wr_en = 1'b1; wr_row.refs = hit_row_q.refs - 16'd1;
          end else clr_live = 1'b1;
        end
        REQ_LOOKUP: begin
          if (!found_q) st = ST_UNREACH;
          else if (scope_q && req_q.iface_index == '0 && amb_q) st = ST_NOTAVAIL;
        end
        default: st = ST_OK;
      endcase
    end
    live_next = live_q;
    if (set_live) live_next[wr_idx] = 1'b1;
    if (clr_live) live_next[hit_idx_q] = 1'b0;
    live_cnt = '0;
    for (int k = 0; k < TableEntries; k++) live_cnt = live_cnt + CntW'(live_next[k]);
  end

  // result word; route fields only for a successful lookup
  always_comb begin
    rsp_d = '0;
    rsp_d.status = st;
    rsp_d.removed_count = 6'(removed_q);
    rsp_d.live_count = 6'(live_cnt);
    if (!bad && req_q.req_type == REQ_LOOKUP && st == ST_OK) begin
      rsp_d.out_prefix_hi = best_q.pfx_hi;
      rsp_d.out_prefix_lo = best_q.pfx_lo;
      rsp_d.out_prefix_len = best_q.len;
      rsp_d.out_gateway_hi = best_q.gw_hi;
      rsp_d.out_gateway_lo = best_q.gw_lo;
      rsp_d.out_metric = best_q.cost;
      rsp_d.out_flags = best_q.kind;
      rsp_d.out_iface = best_q.iface;
      rsp_d.out_device_id = best_q.device;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && wr_en) mem[wr_idx] <= wr_row;
    rd_row_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IdxW'(1);
      if (cur_live && ((req_q.req_type == REQ_DEL_DEV && cur.device == req_q.device_id) ||
                       (req_q.req_type == REQ_EXPIRE && cur_exp)))
        live_q[idx_q] <= 1'b0;
    end else if (cmd_i.finish) begin
      live_q <= live_next;
    end
  end

  // scan bookkeeping and payload; no reset needed, load clears it
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      done_q <= 1'b0; hit_q <= 1'b0; free_q <= 1'b0;
      removed_q <= '0; found_q <= 1'b0; amb_q <= 1'b0;
      scope_q <= is_ll(req_i.addr_hi);
      best_len_q <= '0; best_met_q <= '1; best_if_q <= '0;
    end else if (cmd_i.scan) begin
      if (!cur_live) begin
        if (!free_q) begin free_q <= 1'b1; free_idx_q <= idx_q; end
      end else if (!done_q &&
                   (((req_q.req_type == REQ_ADD || req_q.req_type == REQ_DEL) && key_eq) ||
                    ((req_q.req_type == REQ_ADD_CONN || req_q.req_type == REQ_DEL_CONN)
                     && conn_eq))) begin
        done_q <= 1'b1; hit_q <= 1'b1; hit_idx_q <= idx_q; hit_row_q <= cur;
      end
      if (cur_live && req_q.req_type == REQ_DEL_DEV && cur.device == req_q.device_id)
        removed_q <= removed_q + CntW'(1);
      if (usable) begin
        if (better) begin
          best_len_q <= cur.len; best_met_q <= cur.cost; best_if_q <= cur.iface;
          amb_q <= 1'b0; found_q <= 1'b1; best_q <= cur;
          scope_q <= is_ll(req_q.addr_hi) || is_ll(cur.gw_hi);
        end else if (tie) begin
          if (cur.iface != best_if_q) amb_q <= 1'b1;
          scope_q <= scope_q || is_ll(cur.gw_hi);
        end
      end
    end else if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== design/ipv6_route_table_lpm.sv =====
// ----------------------------------------------------------------------------
// ipv6_route_table_lpm: 32-entry IPv6 route table with longest-prefix lookup
// Controller sequences each request; the datapath holds and scans the table.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request is taken, then the table is
// walked one row per cycle through the single row read port, which fetches
// each row ahead of its scan step into a read register. A finish step applies
// the table update and registers the result, and the result is offered on
// the output channel, where it is held until the output transfer. The input
// is ready again in the cycle after the output transfer, so a new request
// is not taken until the previous result has been transferred. Live bits
// clear at reset; row contents are written whenever a row becomes live.
`default_nettype none

module ipv6_route_table_lpm (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  iprt_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output iprt_pkg::rsp_t  out_data_o
);
  import iprt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence: accept, scan, finish, hold result until transfer
  iprt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  iprt_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_ipv6_route_table_lpm.sv =====
// ----------------------------------------------------------------------------
// tb_ipv6_route_table_lpm: self-checking bench for the IPv6 route table
// Drives add, delete, connected, expire and lookup requests with random idle
// gaps, predicts every response in-bench and compares each whole response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ipv6_route_table_lpm;
  import iprt_pkg::*;

  localparam int NumRows    = 32;
  localparam int NumRandom  = 990;
  localparam int IdleLimit  = 4000;
  localparam int DrainWait  = 80;
  localparam logic [63:0] Never = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  ipv6_route_table_lpm dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the route table
  logic  tbl_live [NumRows];
  row_t  tbl_row  [NumRows];

  req_t  pending_reqs [$];
  rsp_t  expected_rsps [$];
  int    failures;
  bit    stim_done;
  bit    hold_for_drain;  // pause the sender until all responses return

  // Address pools keep adds, deletes and lookups hitting the same routes
  logic [63:0] pool_hi [4];
  logic [63:0] pool_lo [4];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic key_match(row_t r, logic [63:0] phi, logic [63:0] plo,
                                     logic [7:0] len, logic [15:0] dev);
    return r.pfx_hi == phi && r.pfx_lo == plo && r.len == len && r.device == dev;
  endfunction

  function automatic logic row_expired(row_t r, logic [63:0] now);
    return r.expiry != Never && now >= r.expiry;
  endfunction

  // Compute the response for one request and update the shadow table
  function automatic rsp_t route_table_step(req_t q);
    rsp_t        rsp;
    logic [63:0] phi, plo;
    logic        bad, del, found, ambig, scope;
    int          hit, free_row, sel, live, removed;
    logic [7:0]  best_len, rl;
    logic [31:0] best_met;
    logic [15:0] best_if;
    row_t        nr;
    rsp = '0;
    rsp.status = ST_OK;
    phi = '0;
    plo = '0;
    hit = -1;
    free_row = -1;
    sel = -1;
    live = 0;
    removed = 0;
    if (q.pfx_len <= 8'd128) begin
      phi = q.addr_hi & mask_hi(q.pfx_len);
      plo = q.addr_lo & mask_lo(q.pfx_len);
    end
    case (q.req_type)
      REQ_ADD, REQ_DEL: begin
        if (q.req_type == REQ_ADD)
          bad = q.pfx_len > 8'd128 || q.device_id == 0 || q.route_flags[2] ||
                q.gateway_hi[63:56] == 8'hFF ||
                ((q.route_flags[0] == 1'b0) != (q.gateway_hi == 0 && q.gateway_lo == 0));
        else
          bad = q.pfx_len > 8'd128 || q.route_flags[2];
        if (bad) begin
          rsp.status = ST_INVALID;
        end else begin
          del = q.req_type == REQ_DEL || (q.expire_time != Never && q.expire_time <= q.now_time);
          for (int i = 0; i < NumRows; i++) begin
            if (!tbl_live[i]) begin
              if (free_row < 0) free_row = i;
            end else if (key_match(tbl_row[i], phi, plo, q.pfx_len, q.device_id) &&
                         tbl_row[i].gw_hi == q.gateway_hi && tbl_row[i].gw_lo == q.gateway_lo &&
                         tbl_row[i].kind == q.route_flags) begin
              hit = i;
              break;
            end
          end
          if (del) begin
            if (hit >= 0) tbl_live[hit] = 1'b0;
            else if (q.req_type == REQ_DEL) rsp.status = ST_NOENT;
          end else if (hit < 0 && free_row < 0) begin
            rsp.status = ST_NOSPACE;
          end else begin
            nr.refs = '0;
            if (hit >= 0) nr.refs = tbl_row[hit].refs;
            else hit = free_row;
            nr.pfx_hi = phi;
            nr.pfx_lo = plo;
            nr.len = q.pfx_len;
            nr.gw_hi = q.gateway_hi;
            nr.gw_lo = q.gateway_lo;
            nr.cost = q.metric;
            nr.kind = q.route_flags;
            nr.expiry = q.expire_time;
            nr.iface = q.iface_index;
            nr.device = q.device_id;
            tbl_row[hit] = nr;
            tbl_live[hit] = 1'b1;
          end
        end
      end
      REQ_DEL_DEV: begin
        for (int i = 0; i < NumRows; i++)
          if (tbl_live[i] && tbl_row[i].device == q.device_id) begin
            tbl_live[i] = 1'b0;
            removed++;
          end
      end
      REQ_ADD_CONN, REQ_DEL_CONN: begin
        if (q.pfx_len > 8'd128 || (q.req_type == REQ_ADD_CONN && q.device_id == 0)) begin
          rsp.status = ST_INVALID;
        end else begin
          for (int i = 0; i < NumRows; i++) begin
            if (!tbl_live[i]) begin
              if (free_row < 0) free_row = i;
            end else if (key_match(tbl_row[i], phi, plo, q.pfx_len, q.device_id) &&
                         tbl_row[i].kind == FL_CONNECTED) begin
              hit = i;
              break;
            end
          end
          if (q.req_type == REQ_DEL_CONN) begin
            if (hit < 0) rsp.status = ST_NOENT;
            else if (tbl_row[hit].refs > 1) tbl_row[hit].refs--;
            else tbl_live[hit] = 1'b0;
          end else if (hit >= 0) begin
            if (tbl_row[hit].refs == 16'hFFFF) rsp.status = ST_OVERFLOW;
            else tbl_row[hit].refs++;
          end else if (free_row < 0) begin
            rsp.status = ST_NOSPACE;
          end else begin
            nr = '0;
            nr.pfx_hi = phi;
            nr.pfx_lo = plo;
            nr.len = q.pfx_len;
            nr.kind = FL_CONNECTED;
            nr.expiry = Never;
            nr.iface = q.iface_index;
            nr.device = q.device_id;
            nr.refs = 16'd1;
            tbl_row[free_row] = nr;
            tbl_live[free_row] = 1'b1;
          end
        end
      end
      REQ_EXPIRE: begin
        for (int i = 0; i < NumRows; i++)
          if (tbl_live[i] && row_expired(tbl_row[i], q.now_time)) tbl_live[i] = 1'b0;
      end
      REQ_LOOKUP: begin
        found = 1'b0;
        ambig = 1'b0;
        scope = is_ll(q.addr_hi);
        best_len = '0;
        best_met = '1;
        best_if = '0;
        for (int i = 0; i < NumRows; i++) begin
          if (!tbl_live[i] || row_expired(tbl_row[i], q.now_time)) continue;
          if (q.iface_index != 0 && tbl_row[i].iface != q.iface_index) continue;
          rl = tbl_row[i].len;
          if ((q.addr_hi & mask_hi(rl)) != tbl_row[i].pfx_hi ||
              (q.addr_lo & mask_lo(rl)) != tbl_row[i].pfx_lo) continue;
          if (!found || rl > best_len || (rl == best_len && tbl_row[i].cost < best_met)) begin
            best_len = rl;
            best_met = tbl_row[i].cost;
            best_if = tbl_row[i].iface;
            ambig = 1'b0;
            scope = is_ll(q.addr_hi) || is_ll(tbl_row[i].gw_hi);
            found = 1'b1;
            sel = i;
          end else if (rl == best_len && tbl_row[i].cost == best_met) begin
            if (tbl_row[i].iface != best_if) ambig = 1'b1;
            scope = scope || is_ll(tbl_row[i].gw_hi);
          end
        end
        if (!found) begin
          rsp.status = ST_UNREACH;
          sel = -1;
        end else if (scope && q.iface_index == 0 && ambig) begin
          rsp.status = ST_NOTAVAIL;
          sel = -1;
        end
      end
      default: rsp.status = ST_INVALID;
    endcase
    for (int i = 0; i < NumRows; i++)
      if (tbl_live[i]) live++;
    if (sel >= 0) begin
      rsp.out_prefix_hi  = tbl_row[sel].pfx_hi;
      rsp.out_prefix_lo  = tbl_row[sel].pfx_lo;
      rsp.out_prefix_len = tbl_row[sel].len;
      rsp.out_gateway_hi = tbl_row[sel].gw_hi;
      rsp.out_gateway_lo = tbl_row[sel].gw_lo;
      rsp.out_metric     = tbl_row[sel].cost;
      rsp.out_flags      = tbl_row[sel].kind;
      rsp.out_iface      = tbl_row[sel].iface;
      rsp.out_device_id  = tbl_row[sel].device;
    end
    rsp.removed_count = 6'(removed > 63 ? 63 : removed);
    rsp.live_count    = 6'(live > 63 ? 63 : live);
    return rsp;
  endfunction

  // Build a request of the given type from small pools so that keys collide
  function automatic req_t make_req(logic [2:0] kind);
    req_t q;
    int   p;
    q = '0;
    p = $urandom_range(0, 3);
    q.req_type   = kind;
    q.addr_hi    = pool_hi[p];
    q.addr_lo    = pool_lo[p];
    if ($urandom_range(0, 3) == 0) q.addr_hi = q.addr_hi ^ (64'd1 << $urandom_range(0, 63));
    if ($urandom_range(0, 5) == 0) q.addr_lo = rand64();
    case ($urandom_range(0, 9))
      0:       q.pfx_len = 8'd0;
      1:       q.pfx_len = 8'd128;
      2:       q.pfx_len = 8'($urandom_range(129, 255));
      3, 4:    q.pfx_len = 8'd64;
      default: q.pfx_len = 8'($urandom_range(1, 127));
    endcase
    if ($urandom_range(0, 1) == 0) begin
      q.gateway_hi  = '0;
      q.gateway_lo  = '0;
      q.route_flags = {1'b0, 1'($urandom_range(0, 1)), 1'b0};
    end else begin
      q.gateway_hi  = ($urandom_range(0, 1) == 0) ? {10'h3FA, 54'($urandom_range(0, 3))} :
                      rand64();
      q.gateway_lo  = 64'($urandom_range(1, 4));
      q.route_flags = {1'b0, 1'($urandom_range(0, 1)), 1'b1};
    end
    if ($urandom_range(0, 15) == 0) q.route_flags = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 20) == 0) q.gateway_hi = {8'hFF, 56'($urandom)};
    q.metric      = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 3));
    q.now_time    = 64'($urandom_range(100, 200));
    if ($urandom_range(0, 30) == 0) q.now_time = rand64();
    case ($urandom_range(0, 5))
      0:       q.expire_time = 64'($urandom_range(0, 150));
      1:       q.expire_time = rand64();
      default: q.expire_time = Never;
    endcase
    q.device_id   = ($urandom_range(0, 20) == 0) ? 16'd0 :
                    (($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3)));
    q.iface_index = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    return q;
  endfunction

  // Fill the request queue: directed part, then mostly well-formed traffic
  initial begin
    req_t q;
    int   r;
    failures = 0;
    stim_done = 1'b0;
    hold_for_drain = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pool_hi[i] = rand64();
      pool_lo[i] = rand64();
    end
    pool_hi[0] = {10'h3FA, 54'h0};  // link-local destination pool
    pool_hi[1] = {8'hFF, 56'h1};    // multicast destination pool
    for (int i = 0; i < NumRows; i++) begin
      tbl_live[i] = 1'b0;
      tbl_row[i] = '0;
    end
    // Directed: unused type, extremes, each request type
    q = '0; q.req_type = 3'd7; q.addr_hi = '1; q.addr_lo = '1; q.pfx_len = '1;
    q.gateway_hi = '1; q.gateway_lo = '1; q.metric = '1; q.route_flags = '1;
    q.expire_time = '1; q.device_id = '1; q.iface_index = '1; q.now_time = '1;
    pending_reqs.push_back(q);
    q = '0; q.req_type = REQ_ADD; q.device_id = 16'd1; q.expire_time = Never;
    q.iface_index = 16'd1; pending_reqs.push_back(q);                 // default route /0
    q.addr_hi = '1; q.addr_lo = '1; q.pfx_len = 8'd128; q.metric = '1;
    q.device_id = '1; q.iface_index = '1; pending_reqs.push_back(q);  // host route /128
    q.pfx_len = 8'd129; pending_reqs.push_back(q);                    // bad length
    q.pfx_len = 8'd64; q.device_id = 16'd0; pending_reqs.push_back(q); // zero device
    q.device_id = 16'd2; q.route_flags = FL_CONNECTED; pending_reqs.push_back(q);
    q.route_flags = FL_GATEWAY; pending_reqs.push_back(q);            // flag without gateway
    q.gateway_hi = {8'hFF, 56'h0}; q.gateway_lo = 64'd1; pending_reqs.push_back(q); // mcast gw
    // Two equal link-local routes on different interfaces: ambiguous
    q = '0; q.req_type = REQ_ADD; q.addr_hi = {10'h3FA, 54'h0}; q.pfx_len = 8'd10;
    q.expire_time = Never; q.device_id = 16'd3; q.iface_index = 16'd2; q.metric = 32'd5;
    pending_reqs.push_back(q);
    q.device_id = 16'd4; q.iface_index = 16'd3; pending_reqs.push_back(q);
    q.req_type = REQ_LOOKUP; q.iface_index = 16'd0; q.addr_lo = 64'd9;
    pending_reqs.push_back(q);                                        // not available
    q.iface_index = 16'd3; pending_reqs.push_back(q);                 // bound: resolves
    // Add with past expiry acts as delete
    q = '0; q.req_type = REQ_ADD; q.device_id = 16'd3; q.addr_hi = {10'h3FA, 54'h0};
    q.pfx_len = 8'd10; q.iface_index = 16'd2; q.expire_time = 64'd5; q.now_time = 64'd5;
    pending_reqs.push_back(q);
    q.req_type = REQ_DEL; pending_reqs.push_back(q);                  // now no entry
    // Connected refcounting
    q = '0; q.req_type = REQ_ADD_CONN; q.addr_hi = 64'h2001; q.pfx_len = 8'd64;
    q.device_id = 16'd5; q.iface_index = 16'd4; pending_reqs.push_back(q);
    pending_reqs.push_back(q);
    q.req_type = REQ_DEL_CONN; pending_reqs.push_back(q);
    pending_reqs.push_back(q);
    pending_reqs.push_back(q);                                        // no entry
    q = '0; q.req_type = REQ_ADD; q.addr_hi = 64'h3000; q.pfx_len = 8'd16;
    q.device_id = 16'd6; q.expire_time = 64'd50; q.now_time = 64'd10; pending_reqs.push_back(q);
    q.req_type = REQ_LOOKUP; q.addr_hi = 64'h3000_0000; q.now_time = 64'd60;
    pending_reqs.push_back(q);                                        // expired: skip
    q.req_type = REQ_EXPIRE; pending_reqs.push_back(q);
    q = '0; q.req_type = REQ_DEL_DEV; q.device_id = '1; pending_reqs.push_back(q);
    q.device_id = 16'd1; pending_reqs.push_back(q);
    // Fill the table past capacity to reach no space
    for (int i = 0; i < NumRows + 2; i++) begin
      q = '0; q.req_type = REQ_ADD; q.addr_hi = 64'(i) << 40; q.pfx_len = 8'd24;
      q.device_id = 16'd7; q.expire_time = Never; pending_reqs.push_back(q);
    end
    q = '0; q.req_type = REQ_ADD_CONN; q.device_id = 16'd7; q.pfx_len = 8'd8;
    pending_reqs.push_back(q);
    q = '0; q.req_type = REQ_DEL_DEV; q.device_id = 16'd7; pending_reqs.push_back(q);
    // Random part
    for (int n = 0; n < NumRandom; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      q = make_req(REQ_ADD);
      else if (r < 40) q = make_req(REQ_DEL);
      else if (r < 43) q = make_req(REQ_DEL_DEV);
      else if (r < 53) q = make_req(REQ_ADD_CONN);
      else if (r < 60) q = make_req(REQ_DEL_CONN);
      else if (r < 64) q = make_req(REQ_EXPIRE);
      else if (r < 97) q = make_req(REQ_LOOKUP);
      else begin
        q = make_req(3'd7);
        q.req_type = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      end
      pending_reqs.push_back(q);
    end
  end

  // Driver: reset, then feed requests with random gaps
  int in_gap;
  int sent;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= $urandom_range(0, 13);
      sent       <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(route_table_step(in_data_i));
        sent <= sent + 1;
        if (sent == 500) hold_for_drain <= 1'b1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (hold_for_drain && expected_rsps.size() == 0 && !(in_valid_i && in_ready_o))
          hold_for_drain <= 1'b0;
        if (in_gap > 0 || pending_reqs.size() == 0 || hold_for_drain ||
            (sent == 500 && in_valid_i && in_ready_o)) begin
          in_valid_i <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
          if (pending_reqs.size() == 0 && !(in_valid_i && in_ready_o) && !in_valid_i)
            stim_done <= 1'b1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_reqs.pop_front();
          // Keep long bursts without gaps now and then
          in_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end
      end
    end
  end

  // Monitor: random backpressure, compare against the oldest expectation
  int out_gap;
  rsp_t exp_rsp;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, out_data_o);
          failures++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp !== out_data_o) begin
            failures++;
            $display("%0t: response mismatch, expected %h, actual %h",
                     $time, exp_rsp, out_data_o);
            if (exp_rsp.status !== out_data_o.status)
              $display("%0t:   status expected %0d, actual %0d",
                       $time, exp_rsp.status, out_data_o.status);
            if (exp_rsp.live_count !== out_data_o.live_count)
              $display("%0t:   live_count expected %0d, actual %0d",
                       $time, exp_rsp.live_count, out_data_o.live_count);
            if (exp_rsp.removed_count !== out_data_o.removed_count)
              $display("%0t:   removed_count expected %0d, actual %0d",
                       $time, exp_rsp.removed_count, out_data_o.removed_count);
          end
        end
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap     <= out_gap - 1;
      end else if (out_valid_o && out_ready_i) begin
        out_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Reset, then watch for stalls and for the end of traffic
  initial begin
    int idle;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle = 0;
    while (!(stim_done && expected_rsps.size() == 0)) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
    repeat (DrainWait) @(posedge clk_i);
    if (failures == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ipv6_route_table_lpm.f =====
design/iprt_pkg.sv
design/iprt_ctrl.sv
design/iprt_dp.sv
design/ipv6_route_table_lpm.sv
bench/tb_ipv6_route_table_lpm.sv
